FILE: rtl/core/lph_pkg.sv
// Package for the linear probe hash table: sizes, field widths, command codes,
// controller states and the result layout. No dependencies.
`default_nettype none

package lph_pkg;

  localparam int MODULUS   = 128;
  localparam int NUM_SLOTS = MODULUS + 1;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int KEY_W  = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 8;
  localparam int COMP_W = 9;
  localparam int OUT_W  = 24;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_t;

  typedef struct packed {
    logic              table_full;
    logic [COMP_W-1:0] comparisons;
    logic [POS_W-1:0]  position;
    logic              found;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/lph_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 129
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/linear_probe_hash_table_top.sv
// Linear probe hash table, top level: command controller, slot store, result register.
// Depends on lph_pkg and lph_ram.
//
// Usage:
//   Requests enter on the s_ group: s_tuser carries the command (insert, look up,
//   clear), s_tdata the key. One result leaves on the m_ group per request.
//   Slot keys live in a 129 x 32 RAM with registered read; a per-slot valid bit
//   makes a slot that was never written since reset or clear read as empty.
//   Clear, the all-ones key and the unused command finish without probing: the
//   result shows in the cycle after the request is taken.
//   Insert and look up read one slot per cycle starting at key mod 128, with P
//   probes (1 to 129); no new request is taken while probing, and the next
//   request can be taken in the same cycle as the result shows. Each probe uses
//   the single RAM read port once.
//   Reset empties the table at once through the valid bits and drops any result.
//   When the receiver stalls the result holds in m_tdata; a new request is taken
//   only while the result register is empty or being drained.
`default_nettype none

module linear_probe_hash_table_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [lph_pkg::KEY_W-1:0] s_tdata,   // key
  input  wire logic [lph_pkg::CMD_W-1:0] s_tuser,   // command
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic      [lph_pkg::OUT_W-1:0] m_tdata    // found, position[8], comparisons[9],
                                                    // table_full, zero pad[5]
);

  import lph_pkg::*;

  state_t              state, state_next;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   slot_next;
  logic [CNT_W-1:0]    cnt;
  logic [KEY_W-1:0]    key_q;
  logic                is_insert;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic                rd_valid;

  logic                accept;
  logic                start_probe;
  logic [SLOT_W-1:0]   home;
  logic [SLOT_W-1:0]   raddr;
  logic [KEY_W-1:0]    rdata;
  logic [KEY_W-1:0]    slot_key;
  logic                hit, empty, at_limit, done;
  logic                we;
  logic                load_out;
  result_t             res;

  assign accept      = s_tvalid && s_tready;
  assign start_probe = (cmd_t'(s_tuser) == CMD_INSERT || cmd_t'(s_tuser) == CMD_LOOKUP)
                       && s_tdata != EMPTY_KEY;
  assign home        = SLOT_W'(s_tdata % MODULUS);
  assign slot_next   = (SLOT_W + 1)'(slot) + 1'b1 > (SLOT_W + 1)'(MODULUS)
                       ? SLOT_W'(1) : SLOT_W'(slot + 1'b1);

  assign slot_key = rd_valid ? rdata : EMPTY_KEY;
  assign hit      = slot_key == key_q;
  assign empty    = slot_key == EMPTY_KEY;
  assign at_limit = cnt == CNT_W'(NUM_SLOTS);
  assign done     = hit || empty || at_limit;

  lph_ram #(
    .WIDTH(KEY_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (we),
    .waddr(slot),
    .wdata(key_q),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && start_probe) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    raddr    = slot_next;
    we       = 1'b0;
    load_out = 1'b0;
    res      = '0;
    case (state)
      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        raddr    = home;
        load_out = accept && !start_probe;
      end
      ST_PROBE: begin
        load_out = done;
        res.comparisons = COMP_W'({cnt, 1'b0});
        if (hit) begin
          res.found    = 1'b1;
          res.position = POS_W'(slot);
        end else if (empty) begin
          if (is_insert) begin
            we           = 1'b1;
            res.position = POS_W'(slot);
          end
        end else begin
          res.table_full = is_insert;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      rd_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= slot_valid[raddr];
      if (accept && cmd_t'(s_tuser) == CMD_CLEAR) begin
        slot_valid <= '0;
      end else if (we) begin
        slot_valid[slot] <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q     <= s_tdata;
      is_insert <= cmd_t'(s_tuser) == CMD_INSERT;
      slot      <= home;
      cnt       <= CNT_W'(1);
    end else if (state == ST_PROBE && !done) begin
      slot <= slot_next;
      cnt  <= cnt + 1'b1;
    end
    if (load_out) begin
      m_tdata <= OUT_W'(res);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lph_checker.sv
// Port-level checker for the linear probe hash table, bound to the top level.
// Depends on lph_pkg and linear_probe_hash_table_top.
`default_nettype none

module lph_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic [lph_pkg::CMD_W-1:0] s_tuser,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [lph_pkg::OUT_W-1:0] m_tdata
);

  import lph_pkg::*;

  result_t r;
  assign r = result_t'(m_tdata[$bits(result_t)-1:0]);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_CLEAR |=> m_tvalid && m_tdata == '0)
    else $error("clear request did not give an all-zero result");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(r.found && r.table_full) && !r.comparisons[0])
    else $error("found with table_full, or odd comparison count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.table_full |->
      r.position == '0 && r.comparisons == COMP_W'(2 * NUM_SLOTS))
    else $error("table_full result without a full probe run");

endmodule

bind linear_probe_hash_table_top lph_checker u_lph_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire
